>>> src/gbr_pkg.sv
// ----------------------------------------------------------------------------
// gbr_pkg
// Shared types, sizes and helpers for the group block reverser.
// ----------------------------------------------------------------------------
package gbr_pkg;

   localparam int MAX_GROUP = 16;
   localparam int DATA_W    = 32;
   localparam int SIZE_W    = 5;
   localparam int ADDR_W    = $clog2(MAX_GROUP);
   localparam int CNT_W     = $clog2(MAX_GROUP + 1);

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     end_of_list;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] out_value;
      logic                     group_last;
      logic                     list_last;
   } rsp_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              group_last;
      logic              list_last;
   } cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0] group_size;
   } stat_type;

   function automatic logic [CNT_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
      logic [CNT_W-1:0] r;
      if (v == '0) begin
         r = CNT_W'(1);
      end else if (CNT_W'(v) > CNT_W'(MAX_GROUP)) begin
         r = CNT_W'(MAX_GROUP);
      end else begin
         r = CNT_W'(v);
      end
      return r;
   endfunction

endpackage

>>> src/gbr_ram.sv
// ----------------------------------------------------------------------------
// gbr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gbr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/gbr_dpath.sv
// ----------------------------------------------------------------------------
// gbr_dpath
// Group size register, LIFO buffer storage and output word flags.
// ----------------------------------------------------------------------------
module gbr_dpath (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [gbr_pkg::SIZE_W-1:0] csr_wr_data,
   input  logic signed [gbr_pkg::DATA_W-1:0] req_value,
   input  gbr_pkg::cmd_type          cmd,
   output gbr_pkg::stat_type         stat,
   output gbr_pkg::rsp_type          rsp_data
);

   logic [gbr_pkg::CNT_W-1:0]  size_ff;
   logic [gbr_pkg::CNT_W-1:0]  size_in;
   logic                       group_last_ff;
   logic                       list_last_ff;
   logic [gbr_pkg::DATA_W-1:0] rd_data;

   always_comb begin
      size_in = size_ff;
      if (csr_wr_en) begin
         size_in = gbr_pkg::clamp_size(csr_wr_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= gbr_pkg::CNT_W'(1);
      end else begin
         size_ff <= size_in;
      end
      if (cmd.rd_en) begin
         group_last_ff <= cmd.group_last;
         list_last_ff  <= cmd.list_last;
      end
   end

   gbr_ram #(
      .WIDTH(gbr_pkg::DATA_W),
      .DEPTH(gbr_pkg::MAX_GROUP)
   ) u_buf (
      .clock  (clock),
      .wr_en  (cmd.wr_en),
      .wr_addr(cmd.wr_addr),
      .wr_data(req_value),
      .rd_en  (cmd.rd_en),
      .rd_addr(cmd.rd_addr),
      .rd_data(rd_data)
   );

   assign stat.group_size     = size_ff;
   assign rsp_data.out_value  = $signed(rd_data);
   assign rsp_data.group_last = group_last_ff;
   assign rsp_data.list_last  = list_last_ff;

endmodule

>>> src/gbr_ctrl.sv
// ----------------------------------------------------------------------------
// gbr_ctrl
// Collect/drain sequencer: fill count, drain count and output word valid.
// ----------------------------------------------------------------------------
module gbr_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_end_of_list,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  gbr_pkg::stat_type stat,
   output gbr_pkg::cmd_type  cmd
);

   typedef enum logic {
      COLLECT,
      DRAIN
   } state_type;

   state_type                 state_ff;
   state_type                 state_in;
   logic [gbr_pkg::CNT_W-1:0] fill_ff;
   logic [gbr_pkg::CNT_W-1:0] fill_in;
   logic [gbr_pkg::CNT_W-1:0] left_ff;
   logic [gbr_pkg::CNT_W-1:0] left_in;
   logic                      eol_ff;
   logic                      eol_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic [gbr_pkg::CNT_W-1:0] fill_next;
   logic [gbr_pkg::CNT_W-1:0] left_dec;
   logic                      slot_free;
   logic                      last;

   assign fill_next = fill_ff + gbr_pkg::CNT_W'(1);
   assign left_dec  = left_ff - gbr_pkg::CNT_W'(1);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign last      = (left_ff == gbr_pkg::CNT_W'(1));

   always_comb begin
      state_in       = state_ff;
      fill_in        = fill_ff;
      left_in        = left_ff;
      eol_in         = eol_ff;
      cmd.wr_en      = 1'b0;
      cmd.wr_addr    = fill_ff[gbr_pkg::ADDR_W-1:0];
      cmd.rd_en      = 1'b0;
      cmd.rd_addr    = left_dec[gbr_pkg::ADDR_W-1:0];
      cmd.group_last = last;
      cmd.list_last  = last && eol_ff;
      unique case (state_ff)
         COLLECT: begin
            if (req_valid) begin
               cmd.wr_en = 1'b1;
               fill_in   = fill_next;
               if (fill_next >= stat.group_size || req_end_of_list) begin
                  state_in = DRAIN;
                  left_in  = fill_next;
                  eol_in   = req_end_of_list;
                  fill_in  = '0;
               end
            end
         end
         DRAIN: begin
            if (slot_free) begin
               cmd.rd_en = 1'b1;
               left_in   = left_dec;
               if (last) begin
                  state_in = COLLECT;
               end
            end
         end
         default: begin
            state_in = COLLECT;
         end
      endcase
      rsp_valid_in = cmd.rd_en || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= COLLECT;
         fill_ff      <= '0;
         left_ff      <= '0;
         eol_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         left_ff      <= left_in;
         eol_ff       <= eol_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == COLLECT);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> src/group_block_reverser.sv
// ----------------------------------------------------------------------------
// group_block_reverser
// Reverses a word stream in groups of group_size; a short final group,
// closed by end_of_list, is reversed as well.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_ready   gbr_pkg::req_type
//   rsp      out        rsp_valid/rsp_ready   gbr_pkg::rsp_type
//   csr      in         csr_wr_en             group_size (clamped to 1..16)
//
// A group is written to the RAM one word per accepted input, then drained
// with one RAM read per word while the rsp slot is free. The single buffer
// RAM port pair sets this order: input stalls while a group drains.
// Reset is synchronous; fill count clears and group_size returns to 1.
// A stalled rsp word holds in the RAM read register; the drain pauses with it.
// ----------------------------------------------------------------------------
module group_block_reverser (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  gbr_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output gbr_pkg::rsp_type           rsp_data,
   input  logic                       csr_wr_en,
   input  logic [gbr_pkg::SIZE_W-1:0] csr_wr_data
);

   gbr_pkg::cmd_type  cmd;
   gbr_pkg::stat_type stat;

   gbr_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_end_of_list(req_data.end_of_list),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .stat           (stat),
      .cmd            (cmd)
   );

   gbr_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_value  (req_data.value),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_data   (rsp_data)
   );

`ifndef SYNTH
   a_no_rd_wr: assert property (@(posedge clock) disable iff (reset)
      !(cmd.wr_en && cmd.rd_en))
      else $error("buffer written and read in one cycle");

   a_size_range: assert property (@(posedge clock) disable iff (reset)
      stat.group_size != '0 &&
      stat.group_size <= gbr_pkg::CNT_W'(gbr_pkg::MAX_GROUP))
      else $error("group size out of range");

   a_list_in_group: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.list_last |-> rsp_data.group_last)
      else $error("list end not on a group end");

   a_rd_makes_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |=> rsp_valid)
      else $error("drained word not presented");
`endif

endmodule
